### rtl/core/crmt_pkg.sv
// Shared types and constants for the chunk receive map tracker.
`timescale 1ns / 1ps

package crmt_pkg;

  localparam int MAX_CHUNKS_DEF = 4096;
  localparam int MAX_RUNS_DEF   = 16;

  localparam logic [15:0] CHUNK_BYTES_RST = 16'd100;

  localparam logic [1:0] CFG_CHUNK_BYTES = 2'd0;
  localparam logic [1:0] CFG_CHUNK_COUNT = 2'd1;
  localparam logic [1:0] CFG_FILE_SIZE   = 2'd2;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_CHUNK = 2'd1;
  localparam logic [1:0] CMD_SCAN  = 2'd2;

  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_RUN     = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;
  localparam logic [1:0] KIND_CLEAR   = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] chunk_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        bad_chunk;
    logic [27:0] byte_offset;
    logic [15:0] byte_length;
    logic        transfer_done;
    logic [11:0] run_start;
    logic [12:0] run_length;
    logic [12:0] complete_count;
    logic [5:0]  run_total;
    logic        last;
  } rsp_t;

endpackage

### rtl/core/crmt_map_ram.sv
// One-bit-wide received map memory, one write and one registered read port.
`timescale 1ns / 1ps

module crmt_map_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/crmt_mul_unit.sv
// Shared 16x16 multiplier with registered product.
`timescale 1ns / 1ps

module crmt_mul_unit (
  input  logic        clk,
  input  logic [15:0] a,
  input  logic [15:0] b,
  output logic [31:0] p
);

  always_ff @(posedge clk) begin
    p <= {16'b0, a} * {16'b0, b};
  end

endmodule

### rtl/core/chunk_receive_map_tracker_top.sv
// Top level: config registers, command sequencer, map memory and multiplier.
//
// Usage:
//   req channel (req_valid/req_ready, req) takes one command word at a time;
//   rsp channel (rsp_valid/rsp_ready, rsp) returns result words, the final
//   one of each command flagged by last. cfg channel writes the chunk byte
//   size, chunk_count and file_size; it is always ready. The user must see that
//   it is written only while idle; the block itself does not enforce this.
//   Chunk received: map write at accept; states MUL_OFF and MUL_BASE feed
//     offset and final-chunk base to the one multiplier, and FINISH loads the
//     result. Status scan: the map is read one bit per cycle through the
//     registered memory port while the receiver takes every word at once.
//   Clear: one map entry written per cycle, then the clear result word.
//   Command 3 is dropped with no result.
//   After reset the map is swept to zero; req_ready stays low meanwhile. A
//   result register sits on rsp; a stalled receiver holds the sequencer,
//   and a new command is accepted while the last result of the previous
//   one still waits.
`timescale 1ns / 1ps

module chunk_receive_map_tracker_top
  import crmt_pkg::*;
#(
  parameter int MAX_CHUNKS = MAX_CHUNKS_DEF,
  parameter int MAX_RUNS   = MAX_RUNS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [27:0] cfg_data
);

  localparam int AW = $clog2(MAX_CHUNKS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_CHUNKS - 1);
  localparam logic [16:0] MAXC = 17'(MAX_CHUNKS);
  localparam logic [5:0]  MAXR = 6'(MAX_RUNS);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_CLEAR, ST_CLR_DONE, ST_BAD,
    ST_MUL_OFF, ST_MUL_BASE, ST_FINISH,
    ST_PRIME, ST_SCAN, ST_SUMMARY
  } state_t;

  state_t state;

  logic [15:0] chunk_bytes;
  logic [12:0] chunk_count;
  logic [27:0] file_size;

  logic [AW-1:0] clr_pos;
  logic [15:0]   idx;
  logic [27:0]   offset;
  logic [12:0]   pos;
  logic [12:0]   open_start;
  logic [12:0]   open_len;
  logic [12:0]   complete;
  logic [5:0]    runs;

  logic [12:0] count;
  logic [12:0] count_m1;
  logic        free;
  logic        accept;
  logic        bad;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic          got;

  logic [15:0] mul_a;
  logic [31:0] prod;

  logic        room;
  logic [12:0] new_len;
  logic [12:0] new_start;
  logic        at_end;
  logic        emit;

  logic        done;
  logic [31:0] diff;
  logic [15:0] len;

  logic        load;
  rsp_t        rsp_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_bytes <= CHUNK_BYTES_RST;
      chunk_count <= '0;
      file_size   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CHUNK_BYTES: chunk_bytes <= cfg_data[15:0];
        CFG_CHUNK_COUNT: chunk_count <= cfg_data[12:0];
        CFG_FILE_SIZE:   file_size   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign count    = ({4'b0, chunk_count} > MAXC) ? MAXC[12:0] : chunk_count;
  assign count_m1 = count - 13'd1;
  assign free     = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE);
  assign accept   = req_valid && req_ready;
  assign bad      = {3'b0, count} <= req.chunk_index;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_pos;
    mem_wdata = 1'b0;
    if (state == ST_INIT || state == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (accept && req.command == CMD_CHUNK && !bad) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(req.chunk_index);
      mem_wdata = 1'b1;
    end
  end

  always_comb begin
    if (state == ST_SCAN && free) begin
      mem_raddr = AW'(pos + 13'd1);
    end else if (state == ST_SCAN) begin
      mem_raddr = AW'(pos);
    end else begin
      mem_raddr = '0;
    end
  end

  crmt_map_ram #(
    .DEPTH (MAX_CHUNKS),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (got)
  );

  assign mul_a = (state == ST_MUL_OFF) ? idx : {3'b0, count_m1};

  crmt_mul_unit u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (chunk_bytes),
    .p   (prod)
  );

  // scan step for the bit at pos
  assign room      = runs < MAXR;
  assign new_len   = (room && !got) ? open_len + 13'd1 : open_len;
  assign new_start = (room && !got && open_len == 13'd0) ? pos : open_start;
  assign at_end    = (pos == count_m1);
  assign emit      = room && (new_len != 13'd0) && (got || at_end);

  // final-chunk length, prod holds the base here
  assign done = (idx == {3'b0, count_m1});
  assign diff = {4'b0, file_size} - prod;
  always_comb begin
    len = chunk_bytes;
    if (done && ({4'b0, file_size} > prod) && (diff <= {16'b0, chunk_bytes})) begin
      len = diff[15:0];
    end
  end

  // result word for the current state
  always_comb begin
    load     = 1'b0;
    rsp_next = '0;
    unique case (state)
      ST_CLR_DONE: begin
        load          = free;
        rsp_next.kind = KIND_CLEAR;
        rsp_next.last = 1'b1;
      end
      ST_BAD: begin
        load               = free;
        rsp_next.kind      = KIND_ACK;
        rsp_next.bad_chunk = 1'b1;
        rsp_next.last      = 1'b1;
      end
      ST_FINISH: begin
        load                   = free;
        rsp_next.kind          = KIND_ACK;
        rsp_next.byte_offset   = offset;
        rsp_next.byte_length   = len;
        rsp_next.transfer_done = done;
        rsp_next.last          = 1'b1;
      end
      ST_SCAN: begin
        load                = free && emit;
        rsp_next.kind       = KIND_RUN;
        rsp_next.run_start  = new_start[11:0];
        rsp_next.run_length = new_len;
      end
      ST_SUMMARY: begin
        load                    = free;
        rsp_next.kind           = KIND_SUMMARY;
        rsp_next.complete_count = complete;
        rsp_next.run_total      = runs;
        rsp_next.last           = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      clr_pos   <= '0;
      rsp_valid <= 1'b0;
      pos       <= '0;
      open_start <= '0;
      open_len  <= '0;
      complete  <= '0;
      runs      <= '0;
    end else begin
      if (load) begin
        rsp       <= rsp_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_INIT: begin
          clr_pos <= clr_pos + AW'(1);
          if (clr_pos == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            idx <= req.chunk_index;
            unique case (req.command)
              CMD_CLEAR: begin
                clr_pos <= '0;
                state   <= ST_CLEAR;
              end
              CMD_CHUNK: state <= bad ? ST_BAD : ST_MUL_OFF;
              CMD_SCAN: begin
                pos        <= '0;
                open_start <= '0;
                open_len   <= '0;
                complete   <= '0;
                runs       <= '0;
                state      <= ST_PRIME;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_CLEAR: begin
          clr_pos <= clr_pos + AW'(1);
          if (clr_pos == LAST_ADDR) begin
            state <= ST_CLR_DONE;
          end
        end
        ST_CLR_DONE: begin
          if (free) begin
            state <= ST_IDLE;
          end
        end
        ST_BAD: begin
          if (free) begin
            state <= ST_IDLE;
          end
        end
        ST_MUL_OFF: state <= ST_MUL_BASE;
        ST_MUL_BASE: begin
          offset <= prod[27:0];
          state  <= ST_FINISH;
        end
        ST_FINISH: begin
          if (free) begin
            state <= ST_IDLE;
          end
        end
        ST_PRIME: state <= (count == 13'd0) ? ST_SUMMARY : ST_SCAN;
        ST_SCAN: begin
          if (free) begin
            complete   <= complete + {12'b0, got};
            open_start <= new_start;
            if (emit) begin
              runs     <= runs + 6'd1;
              open_len <= '0;
            end else begin
              open_len <= new_len;
            end
            if (at_end) begin
              state <= ST_SUMMARY;
            end else begin
              pos <= pos + 13'd1;
            end
          end
        end
        ST_SUMMARY: begin
          if (free) begin
            pos        <= '0;
            open_start <= '0;
            open_len   <= '0;
            runs       <= '0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_run_not_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind == KIND_RUN |-> !rsp.last && rsp.run_length != 13'd0)
    else $error("run word flagged last or empty");

  a_runs_bounded: assert property (@(posedge clk) disable iff (rst)
    runs <= MAXR)
    else $error("run counter beyond limit");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> pos < count)
    else $error("scan position beyond chunk count");

  a_bad_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.bad_chunk |-> rsp.kind == KIND_ACK && rsp.byte_offset == 28'd0
      && !rsp.transfer_done)
    else $error("bad chunk word carries data");

  a_summary_resets: assert property (@(posedge clk) disable iff (rst)
    state == ST_SUMMARY && free |=> runs == 6'd0 && open_len == 13'd0)
    else $error("scan registers not cleared after summary");

endmodule

### tb/sv/chunk_map_checker_pkg.sv
// Scoreboard for the chunk receive map tracker: map prediction and result checks.
`timescale 1ns / 1ps

package chunk_map_checker_pkg;
  import crmt_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int REPORT_LIMIT = 100;

  class chunk_map_checker;
    logic [15:0] chunk_bytes;
    logic [12:0] chunk_count;
    logic [27:0] file_size;
    bit          received [MAX_CHUNKS_DEF];
    rsp_t        due_results [$];
    int          errors;

    function new();
      chunk_bytes = CHUNK_BYTES_RST;
      chunk_count = '0;
      file_size   = '0;
      foreach (received[i]) received[i] = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void set_reg(logic [1:0] index, logic [27:0] data);
      case (index)
        CFG_CHUNK_BYTES: chunk_bytes = data[15:0];
        CFG_CHUNK_COUNT: chunk_count = data[12:0];
        CFG_FILE_SIZE:   file_size   = data;
        default: ;
      endcase
    endfunction

    // Predicts the result words of one accepted command word.
    function void note_command(req_t w);
      int count;
      int idx;
      int runs;
      int open_start;
      int open_len;
      int complete;
      longint unsigned cs;
      longint unsigned len;
      longint unsigned base;
      rsp_t r;
      count = (chunk_count > MAX_CHUNKS_DEF) ? MAX_CHUNKS_DEF : int'(chunk_count);
      cs = chunk_bytes;
      r = '0;
      case (w.command)
        CMD_CLEAR: begin
          foreach (received[i]) received[i] = 1'b0;
          r.kind = KIND_CLEAR;
          r.last = 1'b1;
          due_results.push_back(r);
        end
        CMD_CHUNK: begin
          idx = w.chunk_index;
          r.kind = KIND_ACK;
          r.last = 1'b1;
          if (idx >= count) begin
            r.bad_chunk = 1'b1;
          end else begin
            received[idx] = 1'b1;
            len = cs;
            if (idx == count - 1) begin
              r.transfer_done = 1'b1;
              base = longint'(count - 1) * cs;
              if (file_size > base && file_size - base <= cs) len = file_size - base;
            end
            r.byte_offset = 28'(longint'(idx) * cs);
            r.byte_length = 16'(len);
          end
          due_results.push_back(r);
        end
        CMD_SCAN: begin
          runs = 0;
          open_start = 0;
          open_len = 0;
          complete = 0;
          for (int p = 0; p < count; p++) begin
            if (received[p]) complete++;
            if (runs < MAX_RUNS_DEF) begin
              if (!received[p]) begin
                if (open_len == 0) open_start = p;
                open_len++;
              end
              if (open_len > 0 && (received[p] || p == count - 1)) begin
                r = '0;
                r.kind = KIND_RUN;
                r.run_start = 12'(open_start);
                r.run_length = 13'(open_len);
                due_results.push_back(r);
                runs++;
                open_len = 0;
              end
            end
          end
          r = '0;
          r.kind = KIND_SUMMARY;
          r.complete_count = 13'(complete);
          r.run_total = 6'(runs);
          r.last = 1'b1;
          due_results.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void compare(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: unexpected result word, expected none, got %h", $time, got);
        return;
      end
      want = due_results.pop_front();
      compare("kind", want.kind, got.kind);
      compare("bad_chunk", want.bad_chunk, got.bad_chunk);
      compare("byte_offset", want.byte_offset, got.byte_offset);
      compare("byte_length", want.byte_length, got.byte_length);
      compare("transfer_done", want.transfer_done, got.transfer_done);
      compare("run_start", want.run_start, got.run_start);
      compare("run_length", want.run_length, got.run_length);
      compare("complete_count", want.complete_count, got.complete_count);
      compare("run_total", want.run_total, got.run_total);
      compare("last", want.last, got.last);
    endfunction
  endclass

endpackage

### tb/sv/tb_top.sv
// Testbench top: drives commands and register writes, checks every result word.
`timescale 1ns / 1ps

module tb_top;
  import crmt_pkg::*;
  import chunk_map_checker_pkg::*;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_ready;
  rsp_t        rsp;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [27:0] cfg_data;

  chunk_map_checker board;
  int words_sent;
  bit send_calm;
  bit take_calm;

  chunk_receive_map_tracker_top DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) board.check_result(rsp);
  end

  // Receiver: random stall before each result word, none while take_calm is set.
  initial begin
    int stall;
    rsp_ready = 1'b0;
    @(posedge clk);
    forever begin
      stall = take_calm ? 0 : $urandom_range(16, 0);
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
    end
  end

  task automatic configure(logic [27:0] size_word, logic [27:0] count_word,
                           logic [27:0] total_word, bit poke_unused);
    logic [1:0]  idx [4];
    logic [27:0] val [4];
    int first;
    idx = '{CFG_UNUSED, CFG_CHUNK_BYTES, CFG_CHUNK_COUNT, CFG_FILE_SIZE};
    val = '{28'($urandom), size_word, count_word, total_word};
    first = poke_unused ? 0 : 1;
    for (int i = first; i < 4; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      board.set_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_command(logic [1:0] command, logic [15:0] index);
    int gap;
    req_t w;
    gap = send_calm ? 0 : $urandom_range(16, 0);
    w.command = command;
    w.chunk_index = index;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= w;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    board.note_command(w);
    if (command != CMD_UNUSED) words_sent++;
  endtask

  // Waits until every predicted word has come, then lets the block go quiet.
  task automatic settle(int hold);
    req_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (hold) @(posedge clk);
  endtask

  task automatic random_phase();
    logic [15:0] cs;
    int count;
    int eff;
    int n;
    int roll;
    bit odd_only;
    longint unsigned fs;
    logic [27:0] size_word;
    logic [27:0] count_word;
    case ($urandom_range(9, 0))
      0: cs = 16'd0;
      1: cs = 16'hFFFF;
      2: cs = 16'($urandom);
      default: cs = 16'($urandom_range(300, 1));
    endcase
    roll = $urandom_range(19, 0);
    if (roll == 0) count = 0;
    else if (roll == 1) count = MAX_CHUNKS_DEF;
    else if (roll == 2) count = $urandom_range(8191, MAX_CHUNKS_DEF + 1);
    else if (roll <= 5) count = $urandom_range(200, 49);
    else count = $urandom_range(48, 1);
    eff = (count > MAX_CHUNKS_DEF) ? MAX_CHUNKS_DEF : count;
    case ($urandom_range(7, 0))
      0: fs = 0;
      1: fs = $urandom;
      2: fs = 28'hFFF_FFFF;
      default: begin
        if (eff == 0) fs = $urandom;
        else fs = longint'(eff - 1) * cs + $urandom_range((cs > 0) ? cs : 1, 1);
      end
    endcase
    // stray upper bits on the narrow registers
    size_word  = ($urandom_range(3, 0) == 0) ? {12'($urandom), cs} : {12'd0, cs};
    count_word = ($urandom_range(3, 0) == 0) ? {15'($urandom), 13'(count)}
                                             : {15'd0, 13'(count)};
    configure(size_word, count_word, 28'(fs), $urandom_range(7, 0) == 0);

    send_calm = ($urandom_range(3, 0) == 0);
    take_calm = ($urandom_range(3, 0) == 0);
    odd_only  = ($urandom_range(2, 0) == 0);
    n = $urandom_range(40, 15);
    if ($urandom_range(1, 0) == 1) send_command(CMD_CLEAR, 16'($urandom));
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(40, 0) == 0) settle(20);
      roll = $urandom_range(99, 0);
      if (roll < 3) begin
        send_command(CMD_CLEAR, 16'($urandom));
      end else if (roll < 15) begin
        send_command(CMD_SCAN, 16'($urandom));
      end else if (roll < 20) begin
        send_command(CMD_CHUNK, ($urandom_range(2, 0) == 0) ? 16'(eff)
                                                            : 16'($urandom_range(65535, eff)));
      end else if (roll < 25) begin
        send_command(CMD_UNUSED, 16'($urandom));
      end else if (eff == 0) begin
        send_command(CMD_CHUNK, 16'($urandom));
      end else if (odd_only && eff >= 2) begin
        send_command(CMD_CHUNK, 16'(2 * $urandom_range((eff - 2) / 2, 0) + 1));
      end else begin
        send_command(CMD_CHUNK, ($urandom_range(9, 0) == 0) ? 16'(eff - 1)
                                                            : 16'($urandom_range(eff - 1, 0)));
      end
    end
  endtask

  initial begin
    req_valid  = 1'b0;
    req        = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_CHUNK_BYTES;
    cfg_data   = '0;
    rst        = 1'b1;
    send_calm  = 1'b0;
    take_calm  = 1'b0;
    words_sent = 0;
    board = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: empty transfer, every index bad, unused command dropped
    send_command(CMD_SCAN, 16'd0);
    send_command(CMD_CHUNK, 16'd0);
    send_command(CMD_UNUSED, 16'hFFFF);
    settle(20);

    // widest sizes, full map, exact remainder on the final chunk
    configure(28'hFFF_FFFF, 28'd4096, 28'd268431360, 1'b1);
    send_command(CMD_CHUNK, 16'd4095);
    send_command(CMD_CHUNK, 16'd0);
    send_command(CMD_CHUNK, 16'd0);
    send_command(CMD_CHUNK, 16'd4096);
    send_command(CMD_CHUNK, 16'hFFFF);
    send_command(CMD_SCAN, 16'd0);
    send_command(CMD_CLEAR, 16'd0);
    send_command(CMD_SCAN, 16'd0);
    settle(20);

    // zero chunk size, count above the map size
    configure(28'd0, 28'd8191, 28'd0, 1'b0);
    send_command(CMD_CHUNK, 16'd4095);
    send_command(CMD_CHUNK, 16'd100);
    send_command(CMD_CHUNK, 16'h8000);
    settle(20);

    // final chunk: file too short, remainder too long, proper remainder
    configure(28'd7, 28'd5, 28'd25, 1'b0);
    send_command(CMD_CHUNK, 16'd4);
    settle(20);
    configure(28'd7, 28'd5, 28'd48, 1'b0);
    send_command(CMD_CHUNK, 16'd4);
    settle(20);
    configure(28'd7, 28'd5, 28'd33, 1'b0);
    send_command(CMD_CHUNK, 16'd4);
    send_command(CMD_CHUNK, 16'd2);
    send_command(CMD_SCAN, 16'd0);
    settle(20);

    while (words_sent < 380) begin
      random_phase();
      settle(20);
    end

    settle(50);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/crmt_pkg.sv
rtl/core/crmt_map_ram.sv
rtl/core/crmt_mul_unit.sv
rtl/core/chunk_receive_map_tracker_top.sv
tb/sv/chunk_map_checker_pkg.sv
tb/sv/tb_top.sv
